/* hdl/bbr_pkg.sv */
// Shared constants for the box blur row pass: configuration register codes,
// field widths, reset values and parameter defaults. No dependencies.
`default_nettype none

package bbr_pkg;

   localparam int MAX_RADIUS_DEF  = 31;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int RADIUS_W  = 5;
   localparam int SCALE_W   = 17;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = SCALE_W;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE  = 1'd1;

   localparam logic [RADIUS_W-1:0] RADIUS_RST = 5'd1;
   localparam logic [SCALE_W-1:0]  SCALE_RST  = 17'd21845;

   // Q16 rounding
   localparam int FRAC_BITS = 16;

endpackage

`default_nettype wire

/* hdl/bbr_req_if.sv */
// Input channel of the box blur row pass: valid/ready plus one sample word.
// Depends on bbr_pkg for the default sample width.
`default_nettype none

interface bbr_req_if
   import bbr_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          row_end;

   modport source (output valid, output sample, output row_end, input ready);
   modport sink   (input valid, input sample, input row_end, output ready);
endinterface

`default_nettype wire

/* hdl/bbr_rsp_if.sv */
// Result channel of the box blur row pass: valid/ready plus one average word.
// Depends on bbr_pkg for the default sample width.
`default_nettype none

interface bbr_rsp_if
   import bbr_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] average;
   logic                          end_of_row;
   logic                          run_last;

   modport source (output valid, output average, output end_of_row, output run_last,
                   input ready);
   modport sink   (input valid, input average, input end_of_row, input run_last,
                   output ready);
endinterface

`default_nettype wire

/* hdl/bbr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bbr_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 64,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* hdl/bbr_scale.sv */
// Scaling unit: registered Q16 multiply of the running sum, then rounding
// and saturation to the sample width. Depends on bbr_pkg.
`default_nettype none

module bbr_scale
   import bbr_pkg::*;
#(
   parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int SUM_BITS    = SAMPLE_BITS + 7
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic signed [SUM_BITS-1:0]    sum,
   input  wire logic        [SCALE_W-1:0]     scale,
   output logic      signed [SAMPLE_BITS-1:0] average
);

   localparam int PW = SUM_BITS + SCALE_W + 1;
   localparam int QW = PW + 1 - FRAC_BITS;

   logic signed [PW-1:0] prod_ff;
   logic signed [PW:0]   rnd;
   logic signed [QW-1:0] quot;

   localparam logic signed [QW-1:0] HI = QW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [QW-1:0] LO = QW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PW'(sum) * $signed({1'b0, scale});
      end
   end

   // arithmetic shift gives floor, matching round-half-up on the scaled sum
   always_comb begin
      rnd  = (PW + 1)'(prod_ff) + (PW + 1)'(1 <<< (FRAC_BITS - 1));
      quot = QW'(rnd >>> FRAC_BITS);
      if (quot > HI) begin
         average = SAMPLE_BITS'(HI);
      end else if (quot < LO) begin
         average = SAMPLE_BITS'(LO);
      end else begin
         average = SAMPLE_BITS'(quot);
      end
   end

endmodule

`default_nettype wire

/* hdl/box_blur_row_pass.sv */
// Box blur row pass: centred moving average with edge replication, one row.
// A taken word passes S_ACC, S_MUL and S_EMIT before its result enters the output
// register; a word without result returns from S_ACC. A new word is taken only in
// S_IDLE. A row end adds right-edge flush steps, read-accumulate-scale like a word,
// around the single window RAM read port. Output back-pressure stalls S_EMIT.
// Reset (synchronous): control, sums, counters, config and output valid; payload
// registers and window RAM are not; only entries written in this row are read.
`default_nettype none

module box_blur_row_pass
   import bbr_pkg::*;
#(
   parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   bbr_req_if.sink                    req,
   bbr_rsp_if.source                  rsp,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int WIN_MAX  = 2 * MAX_RADIUS + 1;
   localparam int DEPTH    = WIN_MAX + 1;           // ring one deeper than the window
   localparam int AW       = $clog2(DEPTH);
   localparam int SUM_BITS = SAMPLE_BITS + 7;
   localparam int CW       = $clog2(3 * MAX_RADIUS + 2); // holds count + flush step
   localparam int NW       = $clog2(WIN_MAX + 1);        // samples in row, saturating
   localparam int TW       = $clog2(MAX_RADIUS + 1);     // flush step

   // sequencer codes
   localparam logic [1:0] S_IDLE = 2'd0;   // waiting for a word
   localparam logic [1:0] S_ACC  = 2'd1;   // RAM data back, update running sum
   localparam logic [1:0] S_MUL  = 2'd2;   // product register loads
   localparam logic [1:0] S_EMIT = 2'd3;   // result into the output register

   // ---------------------------------------------------------------- state
   logic [1:0]                    state_ff, state_in;
   logic [RADIUS_W-1:0]           radius_ff;
   logic [SCALE_W-1:0]            scale_ff;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] first_ff, first_in;
   logic [NW-1:0]                 cnt_ff, cnt_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   logic [TW-1:0]                 t_ff, t_in;

   // current word
   logic signed [SAMPLE_BITS-1:0] s_ff, s_in;
   logic                          last_ff, last_in;

   // output register
   logic                          ov_ff, ov_in;
   logic signed [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic                          eor_ff, eor_in;
   logic                          run_ff, run_in;

   // ---------------------------------------------------------------- datapath
   logic [CW-1:0]                 r_eff, w_eff, vcnt;
   logic [AW+1:0]                 addr_pre, addr_diff;
   logic [AW-1:0]                 rd_addr;
   logic [SAMPLE_BITS-1:0]        rd_data;
   logic signed [SAMPLE_BITS-1:0] old;
   logic signed [SUM_BITS-1:0]    s_ext, old_ext, w_ext, ws;
   logic signed [SAMPLE_BITS-1:0] scaled;
   logic                          row_start, final_step, step_done, req_take;

   assign req_take  = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);

   // radius above the build limit is clamped
   assign r_eff = (32'(radius_ff) > 32'(MAX_RADIUS)) ? CW'(MAX_RADIUS) : CW'(radius_ff);
   assign w_eff = CW'({r_eff, 1'b1});

   // ring slot of the sample leaving the window for step t_in: pos + t - w, wrapped
   always_comb begin
      addr_pre  = (AW + 2)'(pos_ff) + (AW + 2)'(t_in);
      addr_diff = addr_pre - (AW + 2)'(w_eff);
      if (addr_diff[AW+1]) begin
         rd_addr = AW'(addr_diff + (AW + 2)'(DEPTH));
      end else begin
         rd_addr = AW'(addr_diff);
      end
   end

   bbr_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (req_take),
      .wr_addr (pos_ff),
      .wr_data (req.sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // virtual count during the flush; before the window fills, the left edge replicates
   assign vcnt       = CW'(cnt_ff) + CW'(t_ff);
   assign old        = (vcnt < w_eff) ? first_ff : $signed(rd_data);
   assign row_start  = (cnt_ff == '0) && (t_ff == '0);
   assign s_ext      = {{(SUM_BITS - SAMPLE_BITS){s_ff[SAMPLE_BITS-1]}}, s_ff};
   assign old_ext    = {{(SUM_BITS - SAMPLE_BITS){old[SAMPLE_BITS-1]}}, old};
   assign w_ext      = SUM_BITS'(w_eff);
   assign ws         = s_ext * w_ext;                // whole window of the first sample
   assign final_step = !last_ff || (CW'(t_ff) == r_eff);

   bbr_scale #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_scale (
      .clock   (clock),
      .en      (state_ff == S_MUL),
      .sum     (sum_ff),
      .scale   (scale_ff),
      .average (scaled)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in  = state_ff;
      sum_in    = sum_ff;
      first_in  = first_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      t_in      = t_ff;
      s_in      = s_ff;
      last_in   = last_ff;
      ov_in     = ov_ff;
      avg_in    = avg_ff;
      eor_in    = eor_ff;
      run_in    = run_ff;
      step_done = 1'b0;

      if (rsp.valid && rsp.ready) begin
         ov_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               s_in     = req.sample;
               last_in  = req.row_end;
               t_in     = '0;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (row_start) begin
               first_in = s_ff;
               sum_in   = ws;
            end else begin
               sum_in = sum_ff + s_ext - old_ext;
            end
            if (vcnt >= r_eff) begin
               state_in = S_MUL;
            end else begin
               step_done = 1'b1;
            end
         end
         S_MUL: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!ov_ff || rsp.ready) begin
               ov_in     = 1'b1;
               avg_in    = scaled;
               eor_in    = last_ff && final_step;
               run_in    = final_step;
               step_done = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // next flush step, or close the word
      if (step_done) begin
         if (last_ff && (CW'(t_ff) < r_eff)) begin
            t_in     = t_ff + 1'b1;
            state_in = S_ACC;
         end else begin
            t_in     = '0;
            state_in = S_IDLE;
            if (last_ff) begin
               cnt_in = '0;
               pos_in = '0;
               sum_in = '0;
            end else begin
               pos_in = (pos_ff == AW'(DEPTH - 1)) ? '0 : pos_ff + 1'b1;
               cnt_in = (cnt_ff == NW'(WIN_MAX)) ? cnt_ff : cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         radius_ff <= RADIUS_RST;
         scale_ff  <= SCALE_RST;
         sum_ff    <= '0;
         first_ff  <= '0;
         cnt_ff    <= '0;
         pos_ff    <= '0;
         t_ff      <= '0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         first_ff <= first_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         t_ff     <= t_in;
         ov_ff    <= ov_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_RADIUS: radius_ff <= csr_wdata[RADIUS_W-1:0];
               CSR_SCALE:  scale_ff  <= csr_wdata[SCALE_W-1:0];
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      last_ff <= last_in;
      avg_ff  <= avg_in;
      eor_ff  <= eor_in;
      run_ff  <= run_in;
   end

   assign rsp.valid      = ov_ff;
   assign rsp.average    = avg_ff;
   assign rsp.end_of_row = eor_ff;
   assign rsp.run_last   = run_ff;

endmodule

`default_nettype wire
